FILE: rtl/uboot_pkg.sv
// Package with the types, codes and helper functions of the serial bootloader host.
`default_nettype none
package uboot_pkg;

  localparam int MaxResults = 5;
  localparam int ResCntW = $clog2(MaxResults + 1);
  localparam int ResIdxW = $clog2(MaxResults);
  localparam logic [15:0] AckTimeoutReset = 16'd500;
  localparam logic [7:0] AckOk = 8'h79;
  localparam logic [7:0] EraseAll = 8'hFF;
  localparam logic [7:0] ZeroByte = 8'h00;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ACK_CMD,
    PH_ACK_ADDR,
    PH_ACK_LEN,
    PH_ACK_FINAL,
    PH_ACK_ERASE,
    PH_RX_COUNT,
    PH_RX_VERSION,
    PH_RX_BLOCK,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic [1:0] {
    MODE_CMD,
    MODE_RX,
    MODE_TICK,
    MODE_PAYLOAD
  } mode_e;

  typedef enum logic [2:0] {
    CMD_SYNC,
    CMD_GET_CMDS,
    CMD_GET_ID,
    CMD_READ,
    CMD_WRITE,
    CMD_ERASE,
    CMD_EXT_ERASE,
    CMD_GO
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NACK,
    ST_TIMEOUT
  } status_e;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       need_payload;
    logic       done_res;
    status_e    status;
  } result_t;

  typedef struct packed {
    phase_e      phase;
    cmd_e        cmd;
    logic [31:0] addr;
    logic [7:0]  len;
    logic [8:0]  cnt;
    logic [7:0]  xsum;
    logic [15:0] ticks;
  } state_t;

  typedef struct packed {
    mode_e       mode;
    cmd_e        command;
    logic [31:0] address;
    logic [7:0]  length;
    logic [7:0]  rx_byte;
    logic [7:0]  payload_byte;
  } item_t;

  function automatic logic [7:0] cmd_code(cmd_e cmd);
    logic [7:0] code;
    case (cmd)
      CMD_SYNC:      code = 8'h7F;
      CMD_GET_CMDS:  code = 8'h00;
      CMD_GET_ID:    code = 8'h02;
      CMD_READ:      code = 8'h11;
      CMD_WRITE:     code = 8'h31;
      CMD_ERASE:     code = 8'h43;
      CMD_EXT_ERASE: code = 8'h44;
      CMD_GO:        code = 8'h21;
      default:       code = 8'h7F;
    endcase
    return code;
  endfunction

  function automatic result_t mk_tx(logic [7:0] b, logic need);
    result_t r;
    r = '0;
    r.tx_valid = 1'b1;
    r.tx_byte = b;
    r.need_payload = need;
    return r;
  endfunction

  function automatic result_t mk_data(logic [7:0] b, logic done);
    result_t r;
    r = '0;
    r.data_valid = 1'b1;
    r.data_byte = b;
    r.done_res = done;
    return r;
  endfunction

  function automatic result_t mk_done(status_e st);
    result_t r;
    r = '0;
    r.done_res = 1'b1;
    r.status = st;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/uboot_step.sv
// Protocol step logic: next state and result items for one input item.
`default_nettype none
module uboot_step (
  input  uboot_pkg::state_t                      state_i,
  input  uboot_pkg::item_t                       item_i,
  input  logic [15:0]                            timeout_i,
  output uboot_pkg::state_t                      next_state_o,
  output uboot_pkg::result_t                     res_o [uboot_pkg::MaxResults],
  output logic [uboot_pkg::ResCntW-1:0]          res_cnt_o
);

  logic        timed;
  logic        ack_wait;
  logic        is_ack;
  logic [15:0] ticks_inc;
  logic        tick_expired;
  logic [8:0]  cnt_dec;
  logic [7:0]  a3, a2, a1, a0;

  assign timed = (state_i.phase == uboot_pkg::PH_ACK_CMD) ||
                 (state_i.phase == uboot_pkg::PH_ACK_ADDR) ||
                 (state_i.phase == uboot_pkg::PH_ACK_LEN) ||
                 (state_i.phase == uboot_pkg::PH_ACK_FINAL);
  assign ack_wait = timed || (state_i.phase == uboot_pkg::PH_ACK_ERASE);
  assign is_ack = (item_i.rx_byte == uboot_pkg::AckOk);
  assign ticks_inc = state_i.ticks + 16'd1;
  assign tick_expired = (ticks_inc >= timeout_i);
  assign cnt_dec = (state_i.cnt != 9'd0) ? (state_i.cnt - 9'd1) : 9'd0;
  assign a3 = state_i.addr[31:24];
  assign a2 = state_i.addr[23:16];
  assign a1 = state_i.addr[15:8];
  assign a0 = state_i.addr[7:0];

  always_comb begin
    next_state_o = state_i;
    case (item_i.mode)
      uboot_pkg::MODE_CMD: begin
        if (state_i.phase == uboot_pkg::PH_IDLE) begin
          next_state_o.cmd = item_i.command;
          next_state_o.addr = item_i.address;
          next_state_o.len = item_i.length;
          next_state_o.ticks = '0;
          next_state_o.phase = (item_i.command == uboot_pkg::CMD_SYNC) ?
                               uboot_pkg::PH_ACK_FINAL : uboot_pkg::PH_ACK_CMD;
        end
      end
      uboot_pkg::MODE_RX: begin
        if (ack_wait) begin
          next_state_o.ticks = '0;
          if (!is_ack) begin
            next_state_o.phase = uboot_pkg::PH_IDLE;
          end else begin
            case (state_i.phase)
              uboot_pkg::PH_ACK_CMD: begin
                case (state_i.cmd)
                  uboot_pkg::CMD_GET_CMDS, uboot_pkg::CMD_GET_ID:
                    next_state_o.phase = uboot_pkg::PH_RX_COUNT;
                  uboot_pkg::CMD_READ, uboot_pkg::CMD_WRITE, uboot_pkg::CMD_GO:
                    next_state_o.phase = uboot_pkg::PH_ACK_ADDR;
                  uboot_pkg::CMD_ERASE, uboot_pkg::CMD_EXT_ERASE:
                    next_state_o.phase = uboot_pkg::PH_ACK_ERASE;
                  default:
                    next_state_o.phase = uboot_pkg::PH_IDLE;
                endcase
              end
              uboot_pkg::PH_ACK_ADDR: begin
                if (state_i.cmd == uboot_pkg::CMD_READ) begin
                  next_state_o.phase = uboot_pkg::PH_ACK_LEN;
                end else if (state_i.cmd == uboot_pkg::CMD_WRITE) begin
                  next_state_o.xsum = state_i.len;
                  next_state_o.cnt = {1'b0, state_i.len} + 9'd1;
                  next_state_o.phase = uboot_pkg::PH_PAYLOAD;
                end else begin
                  next_state_o.phase = uboot_pkg::PH_IDLE;
                end
              end
              uboot_pkg::PH_ACK_LEN: begin
                next_state_o.cnt = {1'b0, state_i.len} + 9'd1;
                next_state_o.phase = uboot_pkg::PH_RX_BLOCK;
              end
              default: next_state_o.phase = uboot_pkg::PH_IDLE;
            endcase
          end
        end else if (state_i.phase == uboot_pkg::PH_RX_COUNT) begin
          if (state_i.cmd == uboot_pkg::CMD_GET_CMDS) begin
            next_state_o.cnt = {1'b0, item_i.rx_byte};
            next_state_o.phase = uboot_pkg::PH_RX_VERSION;
          end else begin
            next_state_o.cnt = {1'b0, item_i.rx_byte} + 9'd1;
            next_state_o.phase = uboot_pkg::PH_RX_BLOCK;
          end
        end else if (state_i.phase == uboot_pkg::PH_RX_VERSION) begin
          if (state_i.cnt == 9'd0) begin
            next_state_o.ticks = '0;
            next_state_o.phase = uboot_pkg::PH_ACK_FINAL;
          end else begin
            next_state_o.phase = uboot_pkg::PH_RX_BLOCK;
          end
        end else if (state_i.phase == uboot_pkg::PH_RX_BLOCK) begin
          next_state_o.cnt = cnt_dec;
          if (cnt_dec == 9'd0) begin
            if (state_i.cmd == uboot_pkg::CMD_READ) begin
              next_state_o.phase = uboot_pkg::PH_IDLE;
            end else begin
              next_state_o.ticks = '0;
              next_state_o.phase = uboot_pkg::PH_ACK_FINAL;
            end
          end
        end
      end
      uboot_pkg::MODE_TICK: begin
        if (timed) begin
          next_state_o.ticks = ticks_inc;
          if (tick_expired) begin
            next_state_o.phase = uboot_pkg::PH_IDLE;
          end
        end
      end
      uboot_pkg::MODE_PAYLOAD: begin
        if (state_i.phase == uboot_pkg::PH_PAYLOAD) begin
          next_state_o.xsum = state_i.xsum ^ item_i.payload_byte;
          next_state_o.cnt = cnt_dec;
          if (cnt_dec == 9'd0) begin
            next_state_o.ticks = '0;
            next_state_o.phase = uboot_pkg::PH_ACK_FINAL;
          end
        end
      end
      default: next_state_o = state_i;
    endcase
  end

  always_comb begin
    for (int i = 0; i < uboot_pkg::MaxResults; i++) begin
      res_o[i] = '0;
    end
    res_cnt_o = '0;
    case (item_i.mode)
      uboot_pkg::MODE_CMD: begin
        if (state_i.phase == uboot_pkg::PH_IDLE) begin
          res_o[0] = uboot_pkg::mk_tx(uboot_pkg::cmd_code(item_i.command), 1'b0);
          if (item_i.command == uboot_pkg::CMD_SYNC) begin
            res_cnt_o = uboot_pkg::ResCntW'(1);
          end else begin
            res_o[1] = uboot_pkg::mk_tx(~uboot_pkg::cmd_code(item_i.command), 1'b0);
            res_cnt_o = uboot_pkg::ResCntW'(2);
          end
        end
      end
      uboot_pkg::MODE_RX: begin
        if (ack_wait) begin
          if (!is_ack) begin
            res_o[0] = uboot_pkg::mk_done(uboot_pkg::ST_NACK);
            res_cnt_o = uboot_pkg::ResCntW'(1);
          end else begin
            case (state_i.phase)
              uboot_pkg::PH_ACK_CMD: begin
                case (state_i.cmd)
                  uboot_pkg::CMD_GET_CMDS, uboot_pkg::CMD_GET_ID: begin
                    res_cnt_o = '0;
                  end
                  uboot_pkg::CMD_READ, uboot_pkg::CMD_WRITE, uboot_pkg::CMD_GO: begin
                    res_o[0] = uboot_pkg::mk_tx(a3, 1'b0);
                    res_o[1] = uboot_pkg::mk_tx(a2, 1'b0);
                    res_o[2] = uboot_pkg::mk_tx(a1, 1'b0);
                    res_o[3] = uboot_pkg::mk_tx(a0, 1'b0);
                    res_o[4] = uboot_pkg::mk_tx(a3 ^ a2 ^ a1 ^ a0, 1'b0);
                    res_cnt_o = uboot_pkg::ResCntW'(5);
                  end
                  uboot_pkg::CMD_ERASE: begin
                    res_o[0] = uboot_pkg::mk_tx(uboot_pkg::EraseAll, 1'b0);
                    res_o[1] = uboot_pkg::mk_tx(uboot_pkg::ZeroByte, 1'b0);
                    res_cnt_o = uboot_pkg::ResCntW'(2);
                  end
                  uboot_pkg::CMD_EXT_ERASE: begin
                    res_o[0] = uboot_pkg::mk_tx(uboot_pkg::EraseAll, 1'b0);
                    res_o[1] = uboot_pkg::mk_tx(uboot_pkg::EraseAll, 1'b0);
                    res_o[2] = uboot_pkg::mk_tx(uboot_pkg::ZeroByte, 1'b0);
                    res_cnt_o = uboot_pkg::ResCntW'(3);
                  end
                  default: begin
                    res_o[0] = uboot_pkg::mk_done(uboot_pkg::ST_OK);
                    res_cnt_o = uboot_pkg::ResCntW'(1);
                  end
                endcase
              end
              uboot_pkg::PH_ACK_ADDR: begin
                if (state_i.cmd == uboot_pkg::CMD_READ) begin
                  res_o[0] = uboot_pkg::mk_tx(state_i.len, 1'b0);
                  res_o[1] = uboot_pkg::mk_tx(~state_i.len, 1'b0);
                  res_cnt_o = uboot_pkg::ResCntW'(2);
                end else if (state_i.cmd == uboot_pkg::CMD_WRITE) begin
                  res_o[0] = uboot_pkg::mk_tx(state_i.len, 1'b1);
                  res_cnt_o = uboot_pkg::ResCntW'(1);
                end else begin
                  res_o[0] = uboot_pkg::mk_done(uboot_pkg::ST_OK);
                  res_cnt_o = uboot_pkg::ResCntW'(1);
                end
              end
              uboot_pkg::PH_ACK_LEN: begin
                res_cnt_o = '0;
              end
              default: begin
                res_o[0] = uboot_pkg::mk_done(uboot_pkg::ST_OK);
                res_cnt_o = uboot_pkg::ResCntW'(1);
              end
            endcase
          end
        end else if ((state_i.phase == uboot_pkg::PH_RX_COUNT) ||
                     (state_i.phase == uboot_pkg::PH_RX_VERSION)) begin
          res_o[0] = uboot_pkg::mk_data(item_i.rx_byte, 1'b0);
          res_cnt_o = uboot_pkg::ResCntW'(1);
        end else if (state_i.phase == uboot_pkg::PH_RX_BLOCK) begin
          res_o[0] = uboot_pkg::mk_data(item_i.rx_byte,
                                        (cnt_dec == 9'd0) &&
                                        (state_i.cmd == uboot_pkg::CMD_READ));
          res_cnt_o = uboot_pkg::ResCntW'(1);
        end
      end
      uboot_pkg::MODE_TICK: begin
        if (timed && tick_expired) begin
          res_o[0] = uboot_pkg::mk_done(uboot_pkg::ST_TIMEOUT);
          res_cnt_o = uboot_pkg::ResCntW'(1);
        end
      end
      uboot_pkg::MODE_PAYLOAD: begin
        if (state_i.phase == uboot_pkg::PH_PAYLOAD) begin
          if (cnt_dec != 9'd0) begin
            res_o[0] = uboot_pkg::mk_tx(item_i.payload_byte, 1'b1);
            res_cnt_o = uboot_pkg::ResCntW'(1);
          end else begin
            res_o[0] = uboot_pkg::mk_tx(item_i.payload_byte, 1'b0);
            res_o[1] = uboot_pkg::mk_tx(state_i.xsum ^ item_i.payload_byte, 1'b0);
            res_cnt_o = uboot_pkg::ResCntW'(2);
          end
        end
      end
      default: res_cnt_o = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/uart_bootloader_host_core.sv
// Top level of the serial bootloader host: input register, protocol state and result buffer.
`default_nettype none
// An input item (command request, received byte, millisecond tick or write payload byte)
// is taken into an input register and processed once the result buffer is empty or
// hands over its final result item in that same cycle. The results of one input item
// (none to five) are held in that buffer and leave at one per cycle while the output is
// not stalled; the first result item can be taken once the input register has passed
// its input item into the result buffer. Items that make one result item or none flow
// at one per cycle while the output is not stalled. The timeout register is written
// through the configuration channel, which is always ready.
module uart_bootloader_host_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [2:0]  command_i,
  input  logic [31:0] address_i,
  input  logic [7:0]  length_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [7:0]  payload_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        data_valid_o,
  output logic [7:0]  data_byte_o,
  output logic        need_payload_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  output logic        last_o
);

  logic [15:0]                          timeout_q;
  logic                                 in_valid_q, in_valid_d;
  uboot_pkg::item_t                     item_q;
  uboot_pkg::state_t                    state_q, state_d;
  uboot_pkg::result_t                   blk_q [uboot_pkg::MaxResults];
  logic [uboot_pkg::ResCntW-1:0]        blk_cnt_q, blk_cnt_d;
  logic [uboot_pkg::ResIdxW-1:0]        blk_idx_q, blk_idx_d;
  uboot_pkg::result_t                   res [uboot_pkg::MaxResults];
  logic [uboot_pkg::ResCntW-1:0]        res_cnt;
  uboot_pkg::state_t                    step_state;
  uboot_pkg::result_t                   cur;
  logic                                 in_fire;
  logic                                 out_fire;
  logic                                 blk_last;
  logic                                 proc;

  uboot_step u_step (
    .state_i      (state_q),
    .item_i       (item_q),
    .timeout_i    (timeout_q),
    .next_state_o (step_state),
    .res_o        (res),
    .res_cnt_o    (res_cnt)
  );

  assign cfg_ready_o = 1'b1;

  assign out_valid_o = (blk_cnt_q != '0);
  assign out_fire = out_valid_o && !out_stall_i;
  assign blk_last = (uboot_pkg::ResCntW'(blk_idx_q) + uboot_pkg::ResCntW'(1)) == blk_cnt_q;
  assign proc = in_valid_q && (!out_valid_o || (out_fire && blk_last));
  assign in_stall_o = in_valid_q && !proc;
  assign in_fire = in_valid_i && !in_stall_o;

  assign cur = blk_q[blk_idx_q];
  assign tx_valid_o = cur.tx_valid;
  assign tx_byte_o = cur.tx_byte;
  assign data_valid_o = cur.data_valid;
  assign data_byte_o = cur.data_byte;
  assign need_payload_o = cur.need_payload;
  assign done_res_o = cur.done_res;
  assign status_o = cur.status;
  assign last_o = blk_last;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    blk_cnt_d = blk_cnt_q;
    blk_idx_d = blk_idx_q;
    if (proc) begin
      state_d = step_state;
      blk_cnt_d = res_cnt;
      blk_idx_d = '0;
    end else if (out_fire) begin
      if (blk_last) begin
        blk_cnt_d = '0;
        blk_idx_d = '0;
      end else begin
        blk_idx_d = blk_idx_q + uboot_pkg::ResIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= uboot_pkg::AckTimeoutReset;
      in_valid_q <= 1'b0;
      blk_cnt_q <= '0;
      blk_idx_q <= '0;
      state_q.phase <= uboot_pkg::PH_IDLE;
      state_q.cmd <= uboot_pkg::CMD_SYNC;
      state_q.addr <= '0;
      state_q.len <= '0;
      state_q.cnt <= '0;
      state_q.xsum <= '0;
      state_q.ticks <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        timeout_q <= cfg_data_i;
      end
      in_valid_q <= in_valid_d;
      blk_cnt_q <= blk_cnt_d;
      blk_idx_q <= blk_idx_d;
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.mode <= uboot_pkg::mode_e'(mode_i);
      item_q.command <= uboot_pkg::cmd_e'(command_i);
      item_q.address <= address_i;
      item_q.length <= length_i;
      item_q.rx_byte <= rx_byte_i;
      item_q.payload_byte <= payload_byte_i;
    end
    if (proc) begin
      for (int i = 0; i < uboot_pkg::MaxResults; i++) begin
        blk_q[i] <= res[i];
      end
    end
  end

`ifndef ASSERT_OFF
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (uboot_pkg::ResCntW'(blk_idx_q) < blk_cnt_q))
    else $error("result index beyond result count");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> last_o)
    else $error("finished item is not the final result of its input item");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(tx_valid_o && data_valid_o))
    else $error("result carries both a transmit byte and a data byte");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_o))
    else $error("input stalled with no item waiting");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_uart_bootloader_host_core.sv
// Self-checking testbench for the serial bootloader host core with a protocol scoreboard.
`default_nettype none
module tb_uart_bootloader_host_core;
  import uboot_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int ItemsPerSetting = 60;
  localparam logic [7:0][7:0] OPCODE_BY_CMD = {
    8'h21, 8'h44, 8'h43, 8'h31, 8'h11, 8'h02, 8'h00, 8'h7F
  };

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       need_payload;
    logic       done_res;
    status_e    status;
    logic       last;
  } host_out_t;

  class host_scoreboard;
    host_out_t   due_host_outputs[$];
    host_out_t   batch[$];
    int          errors;
    int          outputs_checked;
    int          nacks_seen;
    int          timeouts_seen;
    logic [15:0] ack_limit;
    phase_e      ph;
    cmd_e        cmd;
    logic [31:0] addr;
    logic [7:0]  len;
    logic [8:0]  cnt;
    logic [7:0]  xsum;
    logic [15:0] ticks;

    function new();
      ack_limit = AckTimeoutReset;
      ph = PH_IDLE;
      cmd = CMD_SYNC;
      addr = '0;
      len = '0;
      cnt = '0;
      xsum = '0;
      ticks = '0;
      errors = 0;
      outputs_checked = 0;
      nacks_seen = 0;
      timeouts_seen = 0;
    endfunction

    function void put_out(logic txv, logic [7:0] tx, logic dv, logic [7:0] d, logic need,
                          logic done, status_e st);
      host_out_t r;
      r.tx_valid = txv;
      r.tx_byte = tx;
      r.data_valid = dv;
      r.data_byte = d;
      r.need_payload = need;
      r.done_res = done;
      r.status = st;
      r.last = 1'b0;
      batch.push_back(r);
    endfunction

    function void send_tx(logic [7:0] b, logic need);
      put_out(1'b1, b, 1'b0, 8'h00, need, 1'b0, ST_OK);
    endfunction

    function void send_data(logic [7:0] b, logic done);
      put_out(1'b0, 8'h00, 1'b1, b, 1'b0, done, ST_OK);
    endfunction

    function void close_cmd(status_e st);
      ph = PH_IDLE;
      put_out(1'b0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1, st);
    endfunction

    function void arm_wait(phase_e p);
      ph = p;
      ticks = '0;
    endfunction

    function void predict_host_outputs(item_t it);
      logic      timed;
      logic [7:0] op;
      host_out_t tail;
      timed = (ph >= PH_ACK_CMD) && (ph <= PH_ACK_FINAL);
      batch.delete();
      case (it.mode)
        MODE_CMD: begin
          if (ph == PH_IDLE) begin
            cmd = it.command;
            addr = it.address;
            len = it.length;
            op = OPCODE_BY_CMD[cmd];
            send_tx(op, 1'b0);
            if (cmd == CMD_SYNC) begin
              arm_wait(PH_ACK_FINAL);
            end else begin
              send_tx(~op, 1'b0);
              arm_wait(PH_ACK_CMD);
            end
          end
        end
        MODE_RX: begin
          if (timed || ph == PH_ACK_ERASE) begin
            ticks = '0;
            if (it.rx_byte != AckOk) begin
              close_cmd(ST_NACK);
            end else if (ph == PH_ACK_CMD) begin
              case (cmd)
                CMD_GET_CMDS, CMD_GET_ID: begin
                  ph = PH_RX_COUNT;
                end
                CMD_READ, CMD_WRITE, CMD_GO: begin
                  send_tx(addr[31:24], 1'b0);
                  send_tx(addr[23:16], 1'b0);
                  send_tx(addr[15:8], 1'b0);
                  send_tx(addr[7:0], 1'b0);
                  send_tx(addr[31:24] ^ addr[23:16] ^ addr[15:8] ^ addr[7:0], 1'b0);
                  arm_wait(PH_ACK_ADDR);
                end
                CMD_ERASE: begin
                  send_tx(EraseAll, 1'b0);
                  send_tx(ZeroByte, 1'b0);
                  arm_wait(PH_ACK_ERASE);
                end
                CMD_EXT_ERASE: begin
                  send_tx(EraseAll, 1'b0);
                  send_tx(EraseAll, 1'b0);
                  send_tx(ZeroByte, 1'b0);
                  arm_wait(PH_ACK_ERASE);
                end
                default: begin
                  close_cmd(ST_OK);
                end
              endcase
            end else if (ph == PH_ACK_ADDR && cmd == CMD_READ) begin
              send_tx(len, 1'b0);
              send_tx(~len, 1'b0);
              arm_wait(PH_ACK_LEN);
            end else if (ph == PH_ACK_ADDR && cmd == CMD_WRITE) begin
              send_tx(len, 1'b1);
              xsum = len;
              cnt = {1'b0, len} + 9'd1;
              ph = PH_PAYLOAD;
            end else if (ph == PH_ACK_LEN) begin
              cnt = {1'b0, len} + 9'd1;
              ph = PH_RX_BLOCK;
            end else begin
              close_cmd(ST_OK);
            end
          end else if (ph == PH_RX_COUNT) begin
            send_data(it.rx_byte, 1'b0);
            if (cmd == CMD_GET_CMDS) begin
              cnt = {1'b0, it.rx_byte};
              ph = PH_RX_VERSION;
            end else begin
              cnt = {1'b0, it.rx_byte} + 9'd1;
              ph = PH_RX_BLOCK;
            end
          end else if (ph == PH_RX_VERSION) begin
            send_data(it.rx_byte, 1'b0);
            if (cnt == '0) begin
              arm_wait(PH_ACK_FINAL);
            end else begin
              ph = PH_RX_BLOCK;
            end
          end else if (ph == PH_RX_BLOCK) begin
            if (cnt != '0) begin
              cnt = cnt - 9'd1;
            end
            if (cnt != '0) begin
              send_data(it.rx_byte, 1'b0);
            end else if (cmd == CMD_READ) begin
              send_data(it.rx_byte, 1'b1);
              ph = PH_IDLE;
            end else begin
              send_data(it.rx_byte, 1'b0);
              arm_wait(PH_ACK_FINAL);
            end
          end
        end
        MODE_TICK: begin
          if (timed) begin
            ticks = ticks + 16'd1;
            if (ticks >= ack_limit) begin
              close_cmd(ST_TIMEOUT);
            end
          end
        end
        MODE_PAYLOAD: begin
          if (ph == PH_PAYLOAD) begin
            xsum = xsum ^ it.payload_byte;
            if (cnt != '0) begin
              cnt = cnt - 9'd1;
            end
            if (cnt != '0) begin
              send_tx(it.payload_byte, 1'b1);
            end else begin
              send_tx(it.payload_byte, 1'b0);
              send_tx(xsum, 1'b0);
              arm_wait(PH_ACK_FINAL);
            end
          end
        end
        default: begin
        end
      endcase
      if (batch.size() > 0) begin
        tail = batch.pop_back();
        tail.last = 1'b1;
        batch.push_back(tail);
      end
      foreach (batch[i]) begin
        due_host_outputs.push_back(batch[i]);
      end
    endfunction

    task report(string msg);
      $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) begin
        report($sformatf("output %0d, %s is %0h, expected %0h", outputs_checked, name, got,
                         want));
      end
    endtask

    task check_host_output(host_out_t got);
      host_out_t want;
      if (due_host_outputs.size() == 0) begin
        report($sformatf("unexpected output tx %0b/%02h data %0b/%02h done %0b status %0d",
                         got.tx_valid, got.tx_byte, got.data_valid, got.data_byte,
                         got.done_res, got.status));
        return;
      end
      want = due_host_outputs.pop_front();
      compare_field("tx_valid", 8'(got.tx_valid), 8'(want.tx_valid));
      compare_field("tx_byte", got.tx_byte, want.tx_byte);
      compare_field("data_valid", 8'(got.data_valid), 8'(want.data_valid));
      compare_field("data_byte", got.data_byte, want.data_byte);
      compare_field("need_payload", 8'(got.need_payload), 8'(want.need_payload));
      compare_field("done_res", 8'(got.done_res), 8'(want.done_res));
      compare_field("status", 8'(got.status), 8'(want.status));
      compare_field("last", 8'(got.last), 8'(want.last));
      if (want.done_res && want.status == ST_NACK) begin
        nacks_seen++;
      end
      if (want.done_res && want.status == ST_TIMEOUT) begin
        timeouts_seen++;
      end
      outputs_checked++;
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [2:0]  command_i;
  logic [31:0] address_i;
  logic [7:0]  length_i;
  logic [7:0]  rx_byte_i;
  logic [7:0]  payload_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        tx_valid_o;
  logic [7:0]  tx_byte_o;
  logic        data_valid_o;
  logic [7:0]  data_byte_o;
  logic        need_payload_o;
  logic        done_res_o;
  logic [1:0]  status_o;
  logic        last_o;

  host_scoreboard sb;
  bit             calm;
  int             items_in;

  uart_bootloader_host_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] mostly_small(int top);
    if ($urandom_range(0, 99) < 2) begin
      return 8'($urandom_range(0, 255));
    end
    return 8'($urandom_range(0, top));
  endfunction

  function automatic item_t scrambled_item();
    item_t it;
    it.mode = mode_e'($urandom_range(0, 3));
    it.command = cmd_e'($urandom_range(0, 7));
    it.address = $urandom();
    it.length = 8'($urandom());
    it.rx_byte = 8'($urandom());
    it.payload_byte = 8'($urandom());
    return it;
  endfunction

  function automatic item_t cmd_item(cmd_e c, logic [31:0] a, logic [7:0] l);
    item_t it;
    it = scrambled_item();
    it.mode = MODE_CMD;
    it.command = c;
    it.address = a;
    it.length = l;
    return it;
  endfunction

  function automatic item_t other_item(mode_e m, logic [7:0] b);
    item_t it;
    it = scrambled_item();
    it.mode = m;
    it.rx_byte = b;
    it.payload_byte = b;
    return it;
  endfunction

  function automatic item_t next_random_item(output bit noise);
    item_t it;
    int    roll;
    it = scrambled_item();
    roll = $urandom_range(0, 99);
    noise = 1'b0;
    case (sb.ph)
      PH_IDLE: begin
        if (roll < 88) begin
          it.mode = MODE_CMD;
          it.length = mostly_small(7);
        end else begin
          noise = 1'b1;
        end
      end
      PH_ACK_CMD, PH_ACK_ADDR, PH_ACK_LEN, PH_ACK_FINAL: begin
        if (roll < 72) begin
          it.mode = MODE_RX;
          it.rx_byte = AckOk;
        end else if (roll < 80) begin
          it.mode = MODE_RX;
        end else if (roll < 95) begin
          it.mode = MODE_TICK;
        end else begin
          noise = 1'b1;
        end
      end
      PH_ACK_ERASE: begin
        if (roll < 82) begin
          it.mode = MODE_RX;
          it.rx_byte = AckOk;
        end else if (roll < 90) begin
          it.mode = MODE_RX;
        end else begin
          noise = 1'b1;
        end
      end
      PH_RX_COUNT: begin
        if (roll < 90) begin
          it.mode = MODE_RX;
          it.rx_byte = mostly_small(4);
        end else begin
          noise = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        if (roll < 90) begin
          it.mode = MODE_PAYLOAD;
        end else begin
          noise = 1'b1;
        end
      end
      default: begin
        if (roll < 92) begin
          it.mode = MODE_RX;
        end else begin
          noise = 1'b1;
        end
      end
    endcase
    return it;
  endfunction

  task automatic offer_item(input item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    mode_i <= it.mode;
    command_i <= it.command;
    address_i <= it.address;
    length_i <= it.length;
    rx_byte_i <= it.rx_byte;
    payload_byte_i <= it.payload_byte;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.predict_host_outputs(it);
    items_in++;
  endtask

  task automatic drain_outputs();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.due_host_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_ack_timeout(input logic [15:0] value);
    drain_outputs();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    sb.ack_limit = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : sink_stall
    int stall_left;
    int roll;
    stall_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        roll = $urandom_range(0, 99);
        if (!calm && roll < 25) begin
          if (roll < 17) begin
            stall_left = $urandom_range(1, 2);
          end else if (roll < 24) begin
            stall_left = $urandom_range(3, 8);
          end else begin
            stall_left = $urandom_range(20, 60);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    host_out_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.tx_valid = tx_valid_o;
      got.tx_byte = tx_byte_o;
      got.data_valid = data_valid_o;
      got.data_byte = data_byte_o;
      got.need_payload = need_payload_o;
      got.done_res = done_res_o;
      got.status = status_e'(status_o);
      got.last = last_o;
      sb.check_host_output(got);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Watchdog: %0d cycles passed without any handshake.", quiet);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    item_t       opening[$];
    item_t       it;
    bit          noise;
    int          counted;
    logic [15:0] limits[6];
    sb = new();
    calm = 1'b0;
    items_in = 0;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    mode_i = '0;
    command_i = '0;
    address_i = '0;
    length_i = '0;
    rx_byte_i = '0;
    payload_byte_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The opening sequence runs with a zero timeout, so any timed tick fails at once.
    write_ack_timeout(16'd0);
    opening.push_back(cmd_item(CMD_SYNC, 32'hFFFF_FFFF, 8'hFF));
    opening.push_back(other_item(MODE_RX, AckOk));
    opening.push_back(cmd_item(CMD_GET_ID, 32'h0, 8'h0));
    opening.push_back(other_item(MODE_RX, AckOk));
    opening.push_back(other_item(MODE_RX, 8'h00));
    opening.push_back(other_item(MODE_RX, 8'hFF));
    opening.push_back(other_item(MODE_RX, AckOk));
    opening.push_back(cmd_item(CMD_READ, 32'hFFFF_FFFF, 8'hFF));
    opening.push_back(cmd_item(CMD_GO, 32'h1234_5678, 8'h00));
    opening.push_back(other_item(MODE_RX, AckOk));
    opening.push_back(other_item(MODE_RX, 8'h00));
    opening.push_back(cmd_item(CMD_WRITE, 32'h0, 8'h00));
    opening.push_back(other_item(MODE_RX, AckOk));
    opening.push_back(other_item(MODE_RX, AckOk));
    opening.push_back(other_item(MODE_PAYLOAD, 8'hFF));
    opening.push_back(other_item(MODE_TICK, 8'h00));
    opening.push_back(cmd_item(CMD_ERASE, 32'h0, 8'h0));
    opening.push_back(other_item(MODE_RX, AckOk));
    opening.push_back(other_item(MODE_TICK, 8'h00));
    opening.push_back(other_item(MODE_RX, 8'hFE));
    opening.push_back(cmd_item(CMD_EXT_ERASE, 32'h0, 8'h0));
    opening.push_back(other_item(MODE_RX, AckOk));
    opening.push_back(other_item(MODE_RX, AckOk));
    opening.push_back(other_item(MODE_RX, 8'h55));
    foreach (opening[i]) begin
      offer_item(opening[i]);
    end

    limits[0] = 16'd3;
    limits[1] = 16'd1;
    limits[2] = 16'hFFFF;
    limits[3] = 16'($urandom_range(2, 6));
    limits[4] = 16'd2;
    limits[5] = AckTimeoutReset;
    foreach (limits[k]) begin
      write_ack_timeout(limits[k]);
      calm = (k == 1);
      counted = 0;
      while (counted < ItemsPerSetting) begin
        if (counted % 30 == 29) begin
          drain_outputs();
        end
        it = next_random_item(noise);
        offer_item(it);
        if (!noise) begin
          counted++;
        end
      end
    end

    drain_outputs();
    repeat (12) @(posedge clk_i);
    $display("Sent %0d input items under seven timeout settings from 0 to 65535 ticks.",
             items_in);
    $display("Checked %0d output items; %0d commands were refused and %0d timed out.",
             sb.outputs_checked, sb.nacks_seen, sb.timeouts_seen);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
